@@ src/cubic_spline_evaluator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cubic spline evaluator.
// Each macro assumes signals named clock and reset in the using module.
// ----------------------------------------------------------------------------
`ifndef CUBIC_SPLINE_EVALUATOR_MACROS_SVH
`define CUBIC_SPLINE_EVALUATOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CSE_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/cse_pkg.sv @@
// ----------------------------------------------------------------------------
// Cubic spline evaluator package
// Shared types, constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package cse_pkg;

   localparam int MAX_KNOTS_DEF    = 64;
   localparam int TERMS            = 4;
   localparam int Q_W              = 32;
   localparam int KNOT_COUNT_RESET = 2;

   // Kind of an input item, carried on tuser.
   typedef enum logic [1:0] {
      REQ_LOAD_KNOT  = 2'd0,
      REQ_LOAD_COEFF = 2'd1,
      REQ_EVAL       = 2'd2
   } req_kind_type;

   // Control that travels with an item down the pipeline.
   typedef struct packed {
      logic         valid;
      req_kind_type kind;
      logic [1:0]   term;
   } ctl_type;

   // Saturate a wide signed value to Q16.16; the top bit flags overflow.
   function automatic logic [32:0] sat32(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -66'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   // Sign-extend a Q16.16 value to the wide sum width.
   function automatic logic signed [65:0] ext32(input logic signed [31:0] a);
      return {{34{a[31]}}, a};
   endfunction

   // Product shifted right by 16 with rounding toward minus infinity.
   function automatic logic signed [65:0] fl16(input logic signed [63:0] p);
      return {{18{p[63]}}, p[63:16]};
   endfunction

endpackage

@@ src/cse_locate.sv @@
// ----------------------------------------------------------------------------
// Cubic spline segment locator
// Holds the knot positions, compares all knots in use against x in parallel
// and counts the hits over a registered three-stage tree.
// ----------------------------------------------------------------------------
module cse_locate import cse_pkg::*; #(
   parameter int MAX_KNOTS = MAX_KNOTS_DEF,
   parameter int IDX_W     = $clog2(MAX_KNOTS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  ctl_type                 in_ctl,
   input  logic [IDX_W-1:0]        in_idx,
   input  logic signed [Q_W-1:0]   in_lv,
   input  logic signed [Q_W-1:0]   in_x,
   input  logic [IDX_W-1:0]        knot_n,
   output ctl_type                 out_ctl,
   output logic [IDX_W-1:0]        out_idx,
   output logic signed [Q_W-1:0]   out_lv,
   output logic signed [Q_W-1:0]   out_x,
   output logic [IDX_W-1:0]        out_row
);

   localparam int KI_W   = $clog2(MAX_KNOTS);
   localparam int GROUPS = (MAX_KNOTS + 7) / 8;

   logic signed [Q_W-1:0] knot_ff [MAX_KNOTS];
   logic [MAX_KNOTS-1:0]  hit_in, hit_ff;
   logic [3:0]            grp_in [GROUPS];
   logic [3:0]            grp_ff [GROUPS];
   logic [IDX_W-1:0]      row_in, row_ff;

   ctl_type               ctl_a_ff, ctl_b_ff, ctl_c_ff;
   logic [IDX_W-1:0]      idx_a_ff, idx_b_ff, idx_c_ff;
   logic signed [Q_W-1:0] lv_a_ff, lv_b_ff, lv_c_ff;
   logic signed [Q_W-1:0] x_a_ff, x_b_ff, x_c_ff;

   // Knot registers are written as a load item is accepted.
   always_ff @(posedge clock) begin
      if (adv && in_ctl.valid && in_ctl.kind == REQ_LOAD_KNOT &&
          in_idx < IDX_W'(MAX_KNOTS)) begin
         knot_ff[in_idx[KI_W-1:0]] <= in_lv;
      end
   end

   // One comparator per knot slot; slots past the knots in use never hit.
   always_comb begin
      for (int k = 0; k < MAX_KNOTS; k++) begin
         hit_in[k] = ((IDX_W+1)'(k) < {1'b0, knot_n}) && (knot_ff[k] <= in_x);
      end
   end

   // Partial counts over groups of eight hits.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            if (g * 8 + b < MAX_KNOTS) begin
               grp_in[g] = grp_in[g] + 4'(hit_ff[g * 8 + b]);
            end
         end
      end
   end

   // Final sum of the partial counts gives the segment row.
   always_comb begin
      row_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         row_in = row_in + IDX_W'(grp_ff[g]);
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
      end else if (adv) begin
         ctl_a_ff <= in_ctl;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_b_ff;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff   <= hit_in;
         idx_a_ff <= in_idx;
         lv_a_ff  <= in_lv;
         x_a_ff   <= in_x;
         grp_ff   <= grp_in;
         idx_b_ff <= idx_a_ff;
         lv_b_ff  <= lv_a_ff;
         x_b_ff   <= x_a_ff;
         row_ff   <= row_in;
         idx_c_ff <= idx_b_ff;
         lv_c_ff  <= lv_b_ff;
         x_c_ff   <= x_b_ff;
      end
   end

   assign out_ctl = ctl_c_ff;
   assign out_idx = idx_c_ff;
   assign out_lv  = lv_c_ff;
   assign out_x   = x_c_ff;
   assign out_row = row_ff;

endmodule

@@ src/cubic_spline_evaluator.sv @@
// ----------------------------------------------------------------------------
// Cubic spline evaluator
// Evaluates a piecewise cubic spline, its slope and its curvature in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the req_ stream. tuser carries the kind: load knot, load
//   coefficient or evaluate. Load items write the knot or coefficient tables
//   and give no result. Each evaluate item gives one result on rsp_ with the
//   value, slope, curvature, the segment row and a saturation flag.
//   The knot count is written on csr_ while the block is idle.
// Timing:
//   One item is accepted per cycle while the output is not stalled. An
//   evaluation passes three stages that locate the segment, one that reads
//   the tables, then the Horner chain of three multiply steps in seven stages.
// Reset:
//   Synchronous reset clears all valid bits and sets the knot count to two.
//   Table contents are undefined until loaded.
// Stall:
//   When rsp_tready is low with a result waiting, the whole pipeline holds
//   and req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "cubic_spline_evaluator_macros.svh"

module cubic_spline_evaluator import cse_pkg::*; #(
   parameter int MAX_KNOTS = MAX_KNOTS_DEF,
   parameter int IDX_W     = $clog2(MAX_KNOTS + 1),
   parameter int REQ_W     = ((IDX_W + 2 + 2 * Q_W + 7) / 8) * 8,
   parameter int RSP_W     = ((3 * Q_W + IDX_W + 1 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_wdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // entry_index, term_index, load_value, x_value (from bit 0 up)
   input  logic [REQ_W-1:0] req_tdata,
   // req_type
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // value_out, slope_out, curvature_out, segment_out, overflow_flag
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int KI_W = $clog2(MAX_KNOTS);
   localparam int LV_L = IDX_W + 2;
   localparam int X_L  = LV_L + Q_W;

   logic                  adv;
   logic [IDX_W-1:0]      knot_count_ff, knot_n;
   ctl_type               in_ctl, loc_ctl;
   logic [IDX_W-1:0]      loc_idx, loc_row;
   logic signed [Q_W-1:0] loc_lv, loc_x;
   logic [IDX_W-1:0]      knot_rd;

   logic signed [Q_W-1:0] knot_mem [MAX_KNOTS];
   logic signed [Q_W-1:0] coef_mem [TERMS][MAX_KNOTS+1];

   logic v_d_ff, v_e_ff, v_f_ff, v_g_ff, v_h_ff, v_i_ff, v_j_ff, v_k_ff;

   logic signed [Q_W-1:0] knot_d_ff, x_d_ff;
   logic signed [Q_W-1:0] a_d_ff [TERMS];
   logic [IDX_W-1:0]      row_d_ff, row_e_ff, row_f_ff, row_g_ff;
   logic [IDX_W-1:0]      row_h_ff, row_i_ff, row_j_ff, row_k_ff;

   logic [32:0]           dx_e_in, t_g_in, h_g_in, s_g_in, c_g_in;
   logic [32:0]           hm_i_in, h_i_in, sm_i_in, s_i_in, vm_k_in, v_k_in;
   logic signed [Q_W-1:0] dx_e_ff, dx_f_ff, dx_g_ff, dx_h_ff, dx_i_ff;
   logic signed [Q_W-1:0] a0_e_ff, a0_f_ff, a0_g_ff, a0_h_ff, a0_i_ff;
   logic signed [Q_W-1:0] a0_j_ff, a1_e_ff, a1_f_ff, a1_g_ff, a1_h_ff;
   logic signed [Q_W-1:0] a2_e_ff, a2_f_ff, a3_e_ff;
   logic signed [63:0]    pt_f_ff, ph_h_ff, ps_h_ff, pv_j_ff;
   logic signed [Q_W-1:0] h_g_ff, s_g_ff, c_g_ff, c_h_ff, c_i_ff, c_j_ff, c_k_ff;
   logic signed [Q_W-1:0] h_i_ff, s_i_ff, s_j_ff, s_k_ff, val_k_ff;
   logic                  o_e_ff, o_f_ff, o_g_ff, o_h_ff, o_i_ff, o_j_ff, o_k_ff;
   logic signed [65:0]    t_w;

   // The pipeline moves whenever the output stage is empty or being taken.
   assign adv        = !v_k_ff || rsp_tready;
   assign req_tready = adv;

   // Knot count register and its clamp to the legal range.
   always_ff @(posedge clock) begin
      if (reset) begin
         knot_count_ff <= IDX_W'(KNOT_COUNT_RESET);
      end else if (csr_we) begin
         knot_count_ff <= csr_wdata;
      end
   end

   always_comb begin
      knot_n = knot_count_ff;
      if (knot_count_ff < IDX_W'(2)) knot_n = IDX_W'(2);
      if (knot_count_ff > IDX_W'(MAX_KNOTS)) knot_n = IDX_W'(MAX_KNOTS);
   end

   assign in_ctl.valid = req_tvalid;
   assign in_ctl.kind  = req_kind_type'(req_tuser);
   assign in_ctl.term  = req_tdata[IDX_W+1:IDX_W];

   cse_locate #(
      .MAX_KNOTS (MAX_KNOTS),
      .IDX_W     (IDX_W)
   ) u_locate (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_ctl  (in_ctl),
      .in_idx  (req_tdata[IDX_W-1:0]),
      .in_lv   (req_tdata[LV_L+Q_W-1:LV_L]),
      .in_x    (req_tdata[X_L+Q_W-1:X_L]),
      .knot_n  (knot_n),
      .out_ctl (loc_ctl),
      .out_idx (loc_idx),
      .out_lv  (loc_lv),
      .out_x   (loc_x),
      .out_row (loc_row)
   );

   // Below the knots the row is measured from the first knot.
   assign knot_rd = (loc_row == '0) ? '0 : loc_row - IDX_W'(1);

   // Table stage: loads write here, in order with the reads of evaluations.
   always_ff @(posedge clock) begin
      if (adv && loc_ctl.valid) begin
         case (loc_ctl.kind)
            REQ_LOAD_KNOT: begin
               if (loc_idx < IDX_W'(MAX_KNOTS)) begin
                  knot_mem[loc_idx[KI_W-1:0]] <= loc_lv;
               end
            end
            REQ_LOAD_COEFF: begin
               if (loc_idx <= IDX_W'(MAX_KNOTS)) begin
                  coef_mem[loc_ctl.term][loc_idx] <= loc_lv;
               end
            end
            default: ;
         endcase
      end
      if (adv) begin
         knot_d_ff <= knot_mem[knot_rd[KI_W-1:0]];
         for (int j = 0; j < TERMS; j++) begin
            a_d_ff[j] <= coef_mem[j][loc_row];
         end
         x_d_ff   <= loc_x;
         row_d_ff <= loc_row;
      end
   end

   // Saturation and rounding ahead of each register stage.
   assign dx_e_in = sat32(ext32(x_d_ff) - ext32(knot_d_ff));
   assign t_g_in  = sat32(fl16(pt_f_ff));
   assign t_w     = ext32(t_g_in[31:0]);
   assign h_g_in  = sat32(t_w + ext32(a2_f_ff));
   assign s_g_in  = sat32((t_w <<< 1) + t_w + (ext32(a2_f_ff) <<< 1));
   assign c_g_in  = sat32((ext32(a2_f_ff) <<< 1) + (t_w <<< 2) + (t_w <<< 1));
   assign hm_i_in = sat32(fl16(ph_h_ff));
   assign h_i_in  = sat32(ext32(hm_i_in[31:0]) + ext32(a1_h_ff));
   assign sm_i_in = sat32(fl16(ps_h_ff));
   assign s_i_in  = sat32(ext32(sm_i_in[31:0]) + ext32(a1_h_ff));
   assign vm_k_in = sat32(fl16(pv_j_ff));
   assign v_k_in  = sat32(ext32(vm_k_in[31:0]) + ext32(a0_j_ff));

   // Valid bits of the arithmetic stages; only evaluations go past the tables.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_d_ff <= 1'b0;
         v_e_ff <= 1'b0;
         v_f_ff <= 1'b0;
         v_g_ff <= 1'b0;
         v_h_ff <= 1'b0;
         v_i_ff <= 1'b0;
         v_j_ff <= 1'b0;
         v_k_ff <= 1'b0;
      end else if (adv) begin
         v_d_ff <= loc_ctl.valid && loc_ctl.kind == REQ_EVAL;
         v_e_ff <= v_d_ff;
         v_f_ff <= v_e_ff;
         v_g_ff <= v_f_ff;
         v_h_ff <= v_g_ff;
         v_i_ff <= v_h_ff;
         v_j_ff <= v_i_ff;
         v_k_ff <= v_j_ff;
      end
   end

   // Arithmetic payload: dx, t, the four Horner products and the sums.
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_e_ff  <= dx_e_in[31:0];
         o_e_ff   <= dx_e_in[32];
         a0_e_ff  <= a_d_ff[0];
         a1_e_ff  <= a_d_ff[1];
         a2_e_ff  <= a_d_ff[2];
         a3_e_ff  <= a_d_ff[3];
         row_e_ff <= row_d_ff;

         pt_f_ff  <= a3_e_ff * dx_e_ff;
         dx_f_ff  <= dx_e_ff;
         o_f_ff   <= o_e_ff;
         a0_f_ff  <= a0_e_ff;
         a1_f_ff  <= a1_e_ff;
         a2_f_ff  <= a2_e_ff;
         row_f_ff <= row_e_ff;

         h_g_ff   <= h_g_in[31:0];
         s_g_ff   <= s_g_in[31:0];
         c_g_ff   <= c_g_in[31:0];
         o_g_ff   <= o_f_ff | t_g_in[32] | h_g_in[32] | s_g_in[32] | c_g_in[32];
         dx_g_ff  <= dx_f_ff;
         a0_g_ff  <= a0_f_ff;
         a1_g_ff  <= a1_f_ff;
         row_g_ff <= row_f_ff;

         ph_h_ff  <= h_g_ff * dx_g_ff;
         ps_h_ff  <= s_g_ff * dx_g_ff;
         c_h_ff   <= c_g_ff;
         o_h_ff   <= o_g_ff;
         dx_h_ff  <= dx_g_ff;
         a0_h_ff  <= a0_g_ff;
         a1_h_ff  <= a1_g_ff;
         row_h_ff <= row_g_ff;

         h_i_ff   <= h_i_in[31:0];
         s_i_ff   <= s_i_in[31:0];
         o_i_ff   <= o_h_ff | hm_i_in[32] | h_i_in[32] | sm_i_in[32] | s_i_in[32];
         c_i_ff   <= c_h_ff;
         dx_i_ff  <= dx_h_ff;
         a0_i_ff  <= a0_h_ff;
         row_i_ff <= row_h_ff;

         pv_j_ff  <= h_i_ff * dx_i_ff;
         s_j_ff   <= s_i_ff;
         c_j_ff   <= c_i_ff;
         o_j_ff   <= o_i_ff;
         a0_j_ff  <= a0_i_ff;
         row_j_ff <= row_i_ff;

         val_k_ff <= v_k_in[31:0];
         s_k_ff   <= s_j_ff;
         c_k_ff   <= c_j_ff;
         o_k_ff   <= o_j_ff | vm_k_in[32] | v_k_in[32];
         row_k_ff <= row_j_ff;
      end
   end

   // Result packing.
   assign rsp_tvalid = v_k_ff;
   assign rsp_tdata  = RSP_W'({o_k_ff, row_k_ff, c_k_ff, s_k_ff, val_k_ff});

   // Input is taken exactly when the output side can move.
   `CSE_ASSERT_IMPL(a_ready_rule, 1'b1, req_tready == (!rsp_tvalid || rsp_tready))
   // A result never names a row past the knots in use.
   `CSE_ASSERT_IMPL(a_row_bound, rsp_tvalid, row_k_ff <= knot_n)
   // An evaluation in the table stage moves on when the pipeline advances.
   `CSE_ASSERT_NEXT(a_stage_move, v_d_ff && adv, v_e_ff)
   // A stalled result keeps its flag and row.
   `CSE_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, $stable(row_k_ff) && $stable(o_k_ff))

endmodule
